/* rtl/emot_pkg.sv */
`timescale 1ns / 1ps
package emot_pkg;
  localparam int MaxExtents  = 1024;
  localparam int DeviceSlots = 64;
  localparam int AlignShift  = 21;
  localparam int IdxW = $clog2(MaxExtents);
  localparam int CntW = $clog2(MaxExtents + 1);

  // configuration register indexes
  localparam logic [2:0] REG_MAP_SIZE  = 3'd0;
  localparam logic [2:0] REG_EXT_COUNT = 3'd1;
  localparam logic [2:0] REG_DEV_VALID = 3'd2;
  localparam logic [2:0] REG_DEV_UNUSE = 3'd3;
  localparam logic [2:0] REG_DEV_POISN = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IO       = 3'd1;
  localparam logic [2:0] ST_POISONED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_MISSING  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_PREV, S_LD_PREV_W, S_LD_WRITE, S_LD_LAST, S_LD_LAST_W, S_LD_FINISH,
    S_TR_READ, S_TR_WAIT, S_TR_STEP, S_TR_CHECK, S_OUT
  } state_t;
endpackage

/* rtl/extent_map_offset_translator.sv */
`timescale 1ns / 1ps
// A load steps S_LD_PREV, S_LD_PREV_W, S_LD_WRITE and S_LD_LAST (then S_LD_LAST_W and
// S_LD_FINISH on the extent that completes the map); with the table full it skips the
// write, and once a map is held it goes to the result. A translate with no usable map
// goes to the result too; else it indexes by shift or walks extents through the single
// store read port and the shared subtractor. One request at a time: in_ready returns the
// cycle after the result is taken. Synchronous rst clears config, map and FSM state.
module extent_map_offset_translator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  ext_device,
  input  logic [62:0] ext_base,
  input  logic [62:0] ext_length,
  input  logic [62:0] xlate_offset,
  input  logic [62:0] request_length,
  input  logic [31:0] access_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [62:0] device_address,
  output logic [62:0] mapped_length,
  output logic [5:0]  device_index,
  output logic [31:0] flags_out
);
  localparam int IW = emot_pkg::IdxW;
  localparam int CW = emot_pkg::CntW;

  // configuration
  logic [62:0] map_size;
  logic [10:0] extent_count;
  logic [63:0] dev_valid_mask, dev_unusable_mask, dev_poisoned_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= '0; extent_count <= 11'd1;
      dev_valid_mask <= '0; dev_unusable_mask <= '0; dev_poisoned_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emot_pkg::REG_MAP_SIZE: map_size <= cfg_data[62:0];
        emot_pkg::REG_EXT_COUNT: extent_count <= cfg_data[10:0];
        emot_pkg::REG_DEV_VALID: dev_valid_mask <= cfg_data;
        emot_pkg::REG_DEV_UNUSE: dev_unusable_mask <= cfg_data;
        emot_pkg::REG_DEV_POISN: dev_poisoned_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured request
  logic [7:0]  r_dev;
  logic [62:0] r_base, r_len, r_req;
  logic [31:0] r_flags;

  // extent stores (lengths are 63-bit inputs so top bit is always zero)
  logic [62:0] base_mem [emot_pkg::MaxExtents];
  logic [62:0] len_mem  [emot_pkg::MaxExtents];
  logic [7:0]  dev_mem  [emot_pkg::MaxExtents];
  logic [62:0] base_rd, len_rd;
  logic [7:0]  dev_rd;
  logic        mem_we;
  logic [IW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      base_mem[wr_addr] <= r_base;
      len_mem[wr_addr]  <= r_len;
      dev_mem[wr_addr]  <= r_dev;
    end
    base_rd <= base_mem[rd_addr];
    len_rd  <= len_mem[rd_addr];
    dev_rd  <= dev_mem[rd_addr];
  end

  // map state
  logic [CW-1:0] loaded_count;
  logic [63:0]   length_total, referenced_devices;
  logic          layout_errors, middle_uniform, map_ready, map_faulted;
  logic [62:0]   first_length;
  logic [5:0]    index_shift;
  logic          last_ok;

  // walk state
  logic [CW-1:0] widx;
  logic [62:0]   local_off;

  emot_pkg::state_t state, state_next;

  // clamped wanted count
  logic [CW-1:0] want;
  always_comb begin
    if (extent_count == 11'd0) want = CW'(1);
    else if ({21'd0, extent_count} > 32'(emot_pkg::MaxExtents))
      want = CW'(emot_pkg::MaxExtents);
    else want = CW'(extent_count);
  end

  // shared subtract/compare unit
  logic [63:0] sub_a, sub_b, sub_d;
  logic        sub_lt;
  always_comb begin
    sub_a = {1'b0, local_off};
    sub_b = {1'b0, len_rd};
    unique case (state)
      emot_pkg::S_LD_FINISH: begin sub_a = length_total; sub_b = {1'b0, map_size}; end
      emot_pkg::S_LD_PREV_W: begin sub_a = {1'b0, len_rd}; sub_b = {1'b0, first_length}; end
      emot_pkg::S_LD_LAST_W: begin sub_a = {1'b0, first_length}; sub_b = {1'b0, len_rd}; end
      default: ;
    endcase
    sub_d  = sub_a - sub_b;
    sub_lt = sub_a < sub_b;
  end

  logic [64:0] tot_sum;
  assign tot_sum = {1'b0, length_total} + {2'b0, r_len};
  logic [62:0] align_mask;
  assign align_mask = 63'((64'd1 << emot_pkg::AlignShift) - 64'd1);

  // extent number and offset within it under shift indexing
  logic [62:0] sh_slot, sh_local;
  assign sh_slot  = xlate_offset >> index_shift;
  assign sh_local = xlate_offset & ~(63'h7FFF_FFFF_FFFF_FFFF << index_shift);

  // log2 of the first length (only used when it is a power of two)
  logic [5:0] first_log2;
  always_comb begin
    first_log2 = '0;
    for (int b = 0; b < 63; b++) if (first_length[b]) first_log2 = 6'(b);
  end

  logic shift_ok;
  assign shift_ok = loaded_count > CW'(1) && first_length != '0 &&
                    (first_length & (first_length - 63'd1)) == '0 && middle_uniform && last_ok;

  logic [2:0]  o_status;
  logic [62:0] o_addr, o_len;
  logic [5:0]  o_dev;

  assign in_ready  = (state == emot_pkg::S_IDLE);
  assign out_valid = (state == emot_pkg::S_OUT);
  assign status = o_status; assign device_address = o_addr;
  assign mapped_length = o_len; assign device_index = o_dev;
  assign flags_out = r_flags;

  // sequencer next state
  always_comb begin
    state_next = state;
    mem_we  = 1'b0;
    wr_addr = loaded_count[IW-1:0];
    rd_addr = widx[IW-1:0];
    unique case (state)
      emot_pkg::S_IDLE: if (in_valid) state_next =
        opcode ? emot_pkg::S_TR_READ : emot_pkg::S_LD_PREV;
      emot_pkg::S_LD_PREV: begin
        rd_addr = IW'(loaded_count - CW'(1));
        if (map_ready) state_next = emot_pkg::S_OUT;
        else if (loaded_count >= CW'(emot_pkg::MaxExtents)) state_next = emot_pkg::S_LD_LAST;
        else state_next = emot_pkg::S_LD_PREV_W;
      end
      emot_pkg::S_LD_PREV_W: state_next = emot_pkg::S_LD_WRITE;
      emot_pkg::S_LD_WRITE: begin
        mem_we = 1'b1;
        state_next = emot_pkg::S_LD_LAST;
      end
      emot_pkg::S_LD_LAST: begin
        rd_addr = IW'(loaded_count - CW'(1));
        state_next = (loaded_count < want) ? emot_pkg::S_OUT : emot_pkg::S_LD_LAST_W;
      end
      emot_pkg::S_LD_LAST_W: state_next = emot_pkg::S_LD_FINISH;
      emot_pkg::S_LD_FINISH: state_next = emot_pkg::S_OUT;
      emot_pkg::S_TR_READ: begin
        if (!map_ready || map_faulted) state_next = emot_pkg::S_OUT;
        else state_next = emot_pkg::S_TR_WAIT;
      end
      emot_pkg::S_TR_WAIT: state_next = (index_shift != '0 || widx >= loaded_count)
        ? emot_pkg::S_TR_CHECK : emot_pkg::S_TR_STEP;
      emot_pkg::S_TR_STEP: state_next = sub_lt ? emot_pkg::S_TR_CHECK : emot_pkg::S_TR_READ;
      emot_pkg::S_TR_CHECK: state_next = emot_pkg::S_OUT;
      emot_pkg::S_OUT: if (out_ready) state_next = emot_pkg::S_IDLE;
      default: state_next = emot_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= emot_pkg::S_IDLE;
    else state <= state_next;
  end

  // datapath and map state
  logic [5:0] d6;
  assign d6 = dev_rd[5:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0; length_total <= '0; referenced_devices <= '0;
      layout_errors <= 1'b0; first_length <= '0; middle_uniform <= 1'b1;
      index_shift <= '0; map_ready <= 1'b0; map_faulted <= 1'b0;
    end else begin
      unique case (state)
        emot_pkg::S_IDLE: if (in_valid) begin
          r_dev <= ext_device; r_base <= ext_base; r_len <= ext_length;
          r_req <= request_length; r_flags <= access_flags;
          o_status <= emot_pkg::ST_OK; o_addr <= '0; o_len <= '0; o_dev <= '0;
          // shift indexing picks the extent directly
          if (opcode && index_shift != '0) begin
            widx <= (sh_slot >= 63'(loaded_count)) ? loaded_count : CW'(sh_slot);
            local_off <= sh_local;
          end else begin
            widx <= '0;
            local_off <= xlate_offset;
          end
        end
        emot_pkg::S_LD_PREV_W:
          if (loaded_count >= CW'(2) && sub_d != '0) middle_uniform <= 1'b0;
        emot_pkg::S_LD_WRITE: begin
          if (loaded_count == '0) first_length <= r_len;
          if (r_dev < 8'd64) referenced_devices[r_dev[5:0]] <= 1'b1;
          if (r_dev != '0 || (r_base & align_mask) != '0 || (r_len & align_mask) != '0)
            layout_errors <= 1'b1;
          length_total <= tot_sum[64] ? '1 : tot_sum[63:0];
          loaded_count <= loaded_count + CW'(1);
        end
        emot_pkg::S_LD_FINISH: begin
          if (layout_errors || sub_lt) begin
            o_status <= emot_pkg::ST_REJECTED;
            loaded_count <= '0; length_total <= '0; referenced_devices <= '0;
            layout_errors <= 1'b0; first_length <= '0; middle_uniform <= 1'b1;
            index_shift <= '0;
          end else begin
            map_ready <= 1'b1;
            // last_ok: last extent no longer than the first
            index_shift <= shift_ok ? first_log2 : 6'd0;
            if ((referenced_devices & ~dev_valid_mask & ~dev_unusable_mask) != '0) begin
              map_faulted <= 1'b1;
              o_status <= emot_pkg::ST_MISSING;
            end
          end
        end
        emot_pkg::S_TR_READ:
          if (!map_ready || map_faulted) o_status <= emot_pkg::ST_IO;
        emot_pkg::S_TR_STEP: if (!sub_lt) begin
          local_off <= sub_d[62:0];
          widx <= widx + CW'(1);
        end
        emot_pkg::S_TR_CHECK: begin
          if (widx >= loaded_count || local_off >= len_rd) o_status <= emot_pkg::ST_IO;
          else if (dev_rd >= 8'(emot_pkg::DeviceSlots)) o_status <= emot_pkg::ST_IO;
          else if (!dev_valid_mask[d6] || dev_unusable_mask[d6]) begin
            o_status <= emot_pkg::ST_IO; map_faulted <= 1'b1;
          end else if (dev_poisoned_mask[d6]) begin
            o_status <= emot_pkg::ST_POISONED; map_faulted <= 1'b1;
          end else begin
            o_addr <= base_rd + local_off;
            o_len  <= (r_req < len_rd - local_off) ? r_req : len_rd - local_off;
            o_dev  <= d6;
          end
        end
        default: ;
      endcase
    end
  end

  // last extent no longer than the first, sampled from the compare unit
  always_ff @(posedge clk) begin
    if (state == emot_pkg::S_LD_LAST_W) last_ok <= !sub_lt;
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CW'(emot_pkg::MaxExtents)) else $error("loaded count overflow");
  a_fault_needs_map: assert property (@(posedge clk) disable iff (rst)
    map_faulted |-> map_ready) else $error("fault without map");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= emot_pkg::ST_MISSING) else $error("bad status");
endmodule

/* tb/extent_map_offset_translator_tb.sv */
`timescale 1ns / 1ps
module extent_map_offset_translator_tb;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XLATE = 1'b1;
  localparam longint unsigned MASK63  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned ALIGN   = 64'd1 << emot_pkg::AlignShift;
  localparam int              QUIET_LIMIT = 5000;

  typedef struct packed {
    logic        op;
    logic [7:0]  dev;
    logic [62:0] base;
    logic [62:0] len;
    logic [62:0] off;
    logic [62:0] req;
    logic [31:0] flags;
  } request_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [62:0] addr;
    logic [62:0] mlen;
    logic [5:0]  idx;
    logic [31:0] flags;
  } mapping_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [63:0] data;
    request_t    rq;
    bit          typed;
    logic [2:0]  st;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = 1'b0;
  logic [7:0]  ext_device = '0;
  logic [62:0] ext_base = '0;
  logic [62:0] ext_length = '0;
  logic [62:0] xlate_offset = '0;
  logic [62:0] request_length = '0;
  logic [31:0] access_flags = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [62:0] device_address;
  logic [62:0] mapped_length;
  logic [5:0]  device_index;
  logic [31:0] flags_out;

  extent_map_offset_translator dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the block's registers and map state
  longint unsigned reg_fsize = 0, reg_count = 1;
  longint unsigned reg_valid = 0, reg_unuse = 0, reg_poison = 0;
  longint unsigned ext_base_mem [emot_pkg::MaxExtents];
  longint unsigned ext_len_mem [emot_pkg::MaxExtents];
  int unsigned     ext_dev_mem [emot_pkg::MaxExtents];
  int unsigned     n_loaded = 0;
  longint unsigned len_sum = 0, ref_mask = 0, len_first = 0;
  bit              layout_bad = 0, uniform_mid = 1, map_ok = 0, map_fault = 0;
  int unsigned     shift_sel = 0;

  mapping_t  pending_mappings[$];
  plan_row_t plan_rows[$];
  int        fail_count = 0;
  int        send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
  int        quiet = 0;
  longint unsigned map_span = 0;

  function automatic longint unsigned rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic void restart_map();
    n_loaded = 0; len_sum = 0; ref_mask = 0; layout_bad = 0;
    len_first = 0; uniform_mid = 1; shift_sel = 0;
  endfunction

  function automatic logic [2:0] load_extent(request_t rq);
    longint unsigned want;
    int unsigned k;
    if (map_ok) return emot_pkg::ST_OK;
    want = (reg_count == 0) ? 64'd1 : (reg_count > emot_pkg::MaxExtents) ?
           64'(emot_pkg::MaxExtents) : reg_count;
    k = n_loaded;
    if (k < emot_pkg::MaxExtents) begin
      if (k >= 2 && ext_len_mem[k-1] != len_first) uniform_mid = 0;
      if (k == 0) len_first = 64'(rq.len);
      ext_base_mem[k] = 64'(rq.base);
      ext_len_mem[k] = 64'(rq.len);
      ext_dev_mem[k] = 32'(rq.dev);
      if (rq.dev < 64) ref_mask |= 64'd1 << rq.dev;
      if (rq.dev != 0 || (rq.base & (ALIGN - 1)) != 0 || (rq.len & (ALIGN - 1)) != 0)
        layout_bad = 1;
      len_sum = (len_sum + rq.len < len_sum) ? '1 : len_sum + rq.len;
      k++;
      n_loaded = k;
    end
    if (k < want) return emot_pkg::ST_OK;
    if (layout_bad || len_sum < reg_fsize) begin
      restart_map();
      return emot_pkg::ST_REJECTED;
    end
    shift_sel = 0;
    if (k > 1 && len_first != 0 && (len_first & (len_first - 1)) == 0 && uniform_mid &&
        ext_len_mem[k-1] <= len_first)
      shift_sel = $clog2(len_first);
    map_ok = 1;
    if ((ref_mask & ~reg_valid & ~reg_unuse) != 0) begin
      map_fault = 1;
      return emot_pkg::ST_MISSING;
    end
    return emot_pkg::ST_OK;
  endfunction

  // file offset to device offset, or a load into the shadow map, updating the sticky fault
  function automatic mapping_t predict_mapping(request_t rq);
    mapping_t m;
    longint unsigned slot, rel, rem;
    int unsigned dv;
    m = '0;
    m.flags = rq.flags;
    if (rq.op == OP_LOAD) begin
      m.st = load_extent(rq);
      return m;
    end
    m.st = emot_pkg::ST_IO;
    if (!map_ok || map_fault) return m;
    rel = 64'(rq.off);
    if (shift_sel != 0) begin
      slot = rel >> shift_sel;
      rel = rel & ((64'd1 << shift_sel) - 1);
    end else begin
      for (slot = 0; slot < n_loaded; slot++) begin
        if (rel < ext_len_mem[slot]) break;
        rel -= ext_len_mem[slot];
      end
    end
    if (slot >= n_loaded) return m;
    if (rel >= ext_len_mem[slot]) return m;
    dv = ext_dev_mem[slot];
    if (dv >= emot_pkg::DeviceSlots) return m;
    if (!reg_valid[dv] || reg_unuse[dv]) begin
      map_fault = 1;
      return m;
    end
    if (reg_poison[dv]) begin
      map_fault = 1;
      m.st = emot_pkg::ST_POISONED;
      return m;
    end
    rem = ext_len_mem[slot] - rel;
    m.st = emot_pkg::ST_OK;
    m.addr = 63'(ext_base_mem[slot] + rel);
    m.mlen = (rq.req < rem) ? rq.req : 63'(rem);
    m.idx = 6'(dv);
    return m;
  endfunction

  // register write, only called with the block idle, at a falling edge
  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    case (idx)
      emot_pkg::REG_MAP_SIZE: reg_fsize = val & MASK63;
      emot_pkg::REG_EXT_COUNT: reg_count = val & 64'h7FF;
      emot_pkg::REG_DEV_VALID: reg_valid = val;
      emot_pkg::REG_DEV_UNUSE: reg_unuse = val;
      emot_pkg::REG_DEV_POISN: reg_poison = val;
      default: ;
    endcase
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_masks(longint unsigned v, longint unsigned u, longint unsigned p);
    write_reg(emot_pkg::REG_DEV_VALID, v);
    write_reg(emot_pkg::REG_DEV_UNUSE, u);
    write_reg(emot_pkg::REG_DEV_POISN, p);
  endtask

  // drop valid and wait for every outstanding mapping
  task automatic drain();
    in_valid = 1'b0;
    while (pending_mappings.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // offer one request; the prediction is made on the accepting edge
  task automatic send_request(request_t rq, bit typed = 0,
                              logic [2:0] st = emot_pkg::ST_OK);
    mapping_t m;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    opcode = rq.op; ext_device = rq.dev; ext_base = rq.base; ext_length = rq.len;
    xlate_offset = rq.off; request_length = rq.req; access_flags = rq.flags;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    m = predict_mapping(rq);
    if (typed) begin
      m = '0;
      m.st = st;
      m.flags = rq.flags;
    end
    pending_mappings.push_back(m);
    @(negedge clk);
  endtask

  function automatic request_t mk_load(logic [7:0] dev, longint unsigned base,
                                       longint unsigned len);
    request_t rq;
    rq = '0;
    rq.op = OP_LOAD; rq.dev = dev; rq.base = 63'(base); rq.len = 63'(len);
    rq.flags = $urandom;
    return rq;
  endfunction

  function automatic void plan_cfg(logic [2:0] idx, longint unsigned val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.reg_idx = idx; r.data = val;
    plan_rows.push_back(r);
  endfunction

  function automatic void plan_req(request_t rq, logic [2:0] st);
    plan_row_t r;
    r = '{default: '0};
    r.rq = rq; r.typed = 1; r.st = st;
    plan_rows.push_back(r);
  endfunction

  // a map that is bound to be rejected, or plain junk
  task automatic send_bad_map();
    int n, flaw, bad_at;
    request_t rq;
    n = int'($urandom_range(1, 6));
    flaw = int'($urandom_range(0, 3));
    bad_at = int'($urandom_range(0, n - 1));
    drain();
    write_reg(emot_pkg::REG_EXT_COUNT, 64'(n));
    write_reg(emot_pkg::REG_MAP_SIZE, (flaw >= 2) ? MASK63 : rnd64() & 64'hFF_FFFF);
    for (int j = 0; j < n; j++) begin
      rq = mk_load(8'd0, rnd64() & MASK63 & ~(ALIGN - 1),
                   64'($urandom_range(1, 4)) << emot_pkg::AlignShift);
      if (flaw == 3) begin
        rq.dev = 8'($urandom_range(0, 255));
        rq.base = 63'(rnd64());
        rq.len = 63'(rnd64());
      end else if (j == bad_at && flaw == 0) begin
        rq.dev = 8'($urandom_range(1, 255));
      end else if (j == bad_at && flaw == 1) begin
        rq.base = 63'(rnd64() | 64'd1);
        rq.len = 63'(64'(rq.len) | (64'd1 << $urandom_range(0, emot_pkg::AlignShift - 1)));
      end
      send_request(rq);
      if ($urandom_range(0, 4) == 0) begin
        rq.op = OP_XLATE; rq.off = 63'(rnd64()); rq.req = 63'(rnd64());
        send_request(rq);
      end
    end
  endtask

  // the one map that is accepted in this run
  task automatic send_good_map();
    int n, s;
    bit uniform, faulty;
    longint unsigned lens[8];
    longint unsigned sum, fs;
    n = int'($urandom_range(1, 8));
    uniform = 1'($urandom_range(0, 1));
    faulty = ($urandom_range(0, 7) == 0);
    s = int'(($urandom_range(0, 4) == 0) ? $urandom_range(41, 62) : $urandom_range(21, 30));
    sum = 0;
    for (int j = 0; j < n; j++) begin
      if (!uniform) lens[j] = 64'($urandom_range(1, 16)) << emot_pkg::AlignShift;
      else if (j == n - 1 && n > 1) lens[j] = (64'd1 << s) >> $urandom_range(0, s - 21);
      else lens[j] = 64'd1 << s;
      sum = (sum + lens[j] < sum) ? '1 : sum + lens[j];
    end
    map_span = (sum > MASK63) ? MASK63 : sum;
    fs = ($urandom_range(0, 3) == 0) ? map_span : rnd64() % (map_span + 1);
    drain();
    write_reg(emot_pkg::REG_EXT_COUNT, 64'(n));
    write_reg(emot_pkg::REG_MAP_SIZE, fs);
    if (faulty) write_masks(rnd64() & ~64'd1, rnd64() & ~64'd1, rnd64());
    else write_masks(rnd64() | 64'd1, rnd64() & ~64'd1, rnd64() & ~64'd1);
    for (int j = 0; j < n; j++)
      send_request(mk_load(8'd0, rnd64() & MASK63 & ~(ALIGN - 1), lens[j]));
  endtask

  // translations, mostly inside the map, with a few stray loads
  task automatic send_translations(int count);
    request_t rq;
    for (int j = 0; j < count; j++) begin
      rq = mk_load(8'($urandom_range(0, 255)), rnd64(), rnd64());
      if ($urandom_range(0, 9) != 0) begin
        rq.op = OP_XLATE;
        rq.off = 63'(($urandom_range(0, 9) < 8) ? rnd64() % map_span : rnd64());
        case ($urandom_range(0, 3))
          0: rq.req = 63'($urandom_range(0, 4096));
          1: rq.req = '0;
          2: rq.req = 63'(MASK63);
          default: rq.req = 63'(rnd64());
        endcase
      end
      send_request(rq);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // mapping checker
  always @(posedge clk) begin
    mapping_t m;
    if (!rst && out_valid && out_ready) begin
      if (pending_mappings.size() == 0) begin
        $error("unexpected mapping, status %0d", status);
        fail_count++;
      end else begin
        m = pending_mappings.pop_front();
        if (status !== m.st) begin
          $error("status exp %0d got %0d", m.st, status); fail_count++;
        end
        if (device_address !== m.addr) begin
          $error("device_address exp %h got %h", m.addr, device_address); fail_count++;
        end
        if (mapped_length !== m.mlen) begin
          $error("mapped_length exp %h got %h", m.mlen, mapped_length); fail_count++;
        end
        if (device_index !== m.idx) begin
          $error("device_index exp %0d got %0d", m.idx, device_index); fail_count++;
        end
        if (flags_out !== m.flags) begin
          $error("flags_out exp %h got %h", m.flags, flags_out); fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request or mapping moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    request_t rq;
    // directed plan: no map yet, then each way a map gets rejected
    rq = '0; rq.op = OP_XLATE; rq.flags = '1;
    plan_req(rq, emot_pkg::ST_IO);
    rq.off = 63'(MASK63); rq.req = 63'(MASK63); rq.flags = '0;
    plan_req(rq, emot_pkg::ST_IO);
    plan_req(mk_load(8'd1, 0, ALIGN), emot_pkg::ST_REJECTED);
    plan_req(mk_load(8'd0, 1, ALIGN), emot_pkg::ST_REJECTED);
    plan_req(mk_load(8'd255, 0, ALIGN), emot_pkg::ST_REJECTED);
    plan_req(mk_load(8'd0, 0, ALIGN + 1), emot_pkg::ST_REJECTED);
    plan_cfg(emot_pkg::REG_EXT_COUNT, 0);
    plan_req(mk_load(8'd0, MASK63, MASK63), emot_pkg::ST_REJECTED);
    plan_cfg(emot_pkg::REG_MAP_SIZE, 4 * ALIGN);
    plan_req(mk_load(8'd0, 0, ALIGN), emot_pkg::ST_REJECTED);
    // count lowered below what is loaded: next load closes the map
    plan_cfg(emot_pkg::REG_EXT_COUNT, 64'h7FF);
    for (int j = 0; j < 3; j++) plan_req(mk_load(8'd0, 0, ALIGN), emot_pkg::ST_OK);
    plan_cfg(emot_pkg::REG_EXT_COUNT, 1);
    plan_req(mk_load(8'd64, ALIGN, ALIGN), emot_pkg::ST_REJECTED);
    // saturating total, spoilt by a slot in the last extent
    plan_cfg(emot_pkg::REG_EXT_COUNT, 3);
    plan_cfg(emot_pkg::REG_MAP_SIZE, MASK63);
    plan_req(mk_load(8'd0, MASK63 & ~(ALIGN - 1), MASK63 & ~(ALIGN - 1)), emot_pkg::ST_OK);
    plan_req(mk_load(8'd0, 0, MASK63 & ~(ALIGN - 1)), emot_pkg::ST_OK);
    plan_req(mk_load(8'd2, 0, MASK63 & ~(ALIGN - 1)), emot_pkg::ST_REJECTED);
    plan_cfg(emot_pkg::REG_EXT_COUNT, 1);
    plan_cfg(emot_pkg::REG_MAP_SIZE, 0);
    plan_req(mk_load(8'd128, 0, 0), emot_pkg::ST_REJECTED);
    rq = '0; rq.op = OP_XLATE; rq.flags = 32'hA5A5_5A5A;
    plan_req(rq, emot_pkg::ST_IO);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan_rows[r]) begin
      if (plan_rows[r].is_cfg) begin
        drain();
        write_reg(plan_rows[r].reg_idx, plan_rows[r].data);
      end else begin
        send_request(plan_rows[r].rq, 1'b1, plan_rows[r].st);
      end
    end

    // rejected maps under light idling
    send_idle_pct = 10; recv_stall_pct = 10;
    for (int j = 0; j < 20; j++) send_bad_map();
    send_good_map();

    // translation phases; first one runs into a long receiver hold-off
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_cycles = 400;
    send_translations(110);
    drain();
    write_masks('1 , 0, 0);
    write_reg(emot_pkg::REG_MAP_SIZE, MASK63);
    send_idle_pct = 85;
    send_translations(110);
    drain();
    write_masks(64'd1, ~64'd1, ~64'd1);
    write_reg(emot_pkg::REG_EXT_COUNT, 64'h7FF);
    send_idle_pct = 0; recv_stall_pct = 85;
    send_translations(110);
    drain();
    write_masks(rnd64() | 64'd1, rnd64() & ~64'd1, rnd64() & ~64'd1);
    send_idle_pct = 10; recv_stall_pct = 10;
    send_translations(110);
    // poisoned slot: at most one poisoned mapping, then the map stays faulted
    drain();
    write_reg(emot_pkg::REG_DEV_POISN, '1);
    send_translations(20);

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_mappings.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

/* extent_map_offset_translator.f */
rtl/emot_pkg.sv
rtl/extent_map_offset_translator.sv
tb/extent_map_offset_translator_tb.sv
